// File: hdl/blpg_pkg.sv
// shared types and constants of the bresenham line pixel generator
`timescale 1ns / 1ps

package blpg_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 2160;

    localparam int WIDTH_BITS  = 13;
    localparam int HEIGHT_BITS = 12;
    localparam int ADDR_BITS   = 32;
    localparam int COLOR_BITS  = 32;
    localparam int CFG_BITS    = 32;

    // spans and error term grow by one bit each
    localparam int SPAN_BITS = COORD_BITS + 1;
    localparam int NSY_BITS  = COORD_BITS + 2;
    localparam int ERR_BITS  = COORD_BITS + 3;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        CFG_MODE_ENABLED,
        CFG_SCREEN_WIDTH,
        CFG_SCREEN_HEIGHT,
        CFG_FRAME_BASE
    } t_cfg_idx;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic                  mode;
        t_coord                start_x;
        t_coord                start_y;
        t_coord                end_x;
        t_coord                end_y;
        logic [COLOR_BITS-1:0] color;
    } t_line_in;

    typedef struct packed {
        logic                  point_valid;
        t_coord                pixel_x;
        t_coord                pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  write_enable;
        logic [ADDR_BITS-1:0]  pixel_address;
        logic                  last_point;
    } t_pixel_out;

endpackage

// File: hdl/bresenham_line_pixel_gen.sv
// top level of the bresenham line pixel generator
`timescale 1ns / 1ps

// One beat in gives one pixel beat out. A start beat (mode 0) loads both endpoints and the
// colour and yields the first endpoint; each advance beat (mode 1) takes one all-octant
// Bresenham step and yields the next point, the one equal to the second endpoint flagged as
// last_point. An advance with no line in progress yields a beat with every field zero. The
// block takes one beat per cycle while o_stall is low: the error-term step is a combinational
// set of adds and compares on the line registers, so it sets the rate. A result is offered on
// o_valid from the last stage register of a three-stage elastic pipe (step, row-offset
// multiply of y by the screen width, address add); a stalled output fills the empty stages
// before o_stall rises. write_enable needs mode_enabled and a point with 0 <= x < width and
// 0 <= y < height, width and height saturated at the package maxima. Configuration writes
// take effect at once and are meant for idle periods only.
module bresenham_line_pixel_gen
    import blpg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    // command beats
    input  logic                i_valid,
    output logic                o_stall,
    input  t_line_in            i_in,
    // pixel beats
    output logic                o_valid,
    input  logic                i_stall,
    output t_pixel_out          o_out
);

    typedef struct packed {
        logic                  pv;
        t_coord                x;
        t_coord                y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_pt;

    typedef struct packed {
        t_pt                  pt;
        logic                 on;
        logic [ADDR_BITS-1:0] row_ofs;
    } t_pt_mul;

    // configuration registers
    logic                   r_mode_enabled;
    logic [WIDTH_BITS-1:0]  r_screen_width;
    logic [HEIGHT_BITS-1:0] r_screen_height;
    logic [ADDR_BITS-1:0]   r_frame_base;

    // line state
    t_coord                       r_pos_x, r_pos_y, r_target_x, r_target_y;
    t_coord                       n_pos_x, n_pos_y, n_target_x, n_target_y;
    logic                         r_dir_x_neg, r_dir_y_neg, n_dir_x_neg, n_dir_y_neg;
    logic [SPAN_BITS-1:0]         r_span_x, n_span_x;
    logic signed [NSY_BITS-1:0]   r_neg_span_y, n_neg_span_y;
    logic signed [ERR_BITS-1:0]   r_error_term, n_error_term;
    logic [COLOR_BITS-1:0]        r_line_color, n_line_color;
    logic                         r_line_active, n_line_active;

    // pipe stages
    logic    r_s1_v, r_s2_v, r_s3_v;
    t_pt     r_s1, n_s1;
    t_pt_mul r_s2, n_s2;
    t_pixel_out r_s3, n_s3;

    logic s1_free, s2_free, s3_free, accept;

    // elastic hand-off, a stage loads when it is empty or the next one drains or is empty
    assign s3_free = !r_s3_v || !i_stall;
    assign s2_free = !r_s2_v || s3_free;
    assign s1_free = !r_s1_v || s2_free;
    assign accept  = i_valid && s1_free;
    assign o_stall = !s1_free;
    assign o_valid = r_s3_v;
    assign o_out   = r_s3;

    // effective geometry, saturated at the maxima
    logic [WIDTH_BITS-1:0]  eff_w;
    logic [HEIGHT_BITS-1:0] eff_h;

    always_comb begin
        eff_w = ({1'b0, r_screen_width} > (WIDTH_BITS + 1)'(MAX_WIDTH))
              ? WIDTH_BITS'(MAX_WIDTH) : r_screen_width;
        eff_h = ({2'b0, r_screen_height} > (HEIGHT_BITS + 2)'(MAX_HEIGHT))
              ? HEIGHT_BITS'(MAX_HEIGHT) : r_screen_height;
    end

    // bresenham step: start load or one error-term step
    logic signed [SPAN_BITS-1:0] dx, dy;
    logic [SPAN_BITS-1:0]        ady;
    logic signed [ERR_BITS:0]    e2, nsy_w, sx_w, err_sum;
    logic                        step_x, step_y;
    t_coord                      pt_x, pt_y;

    always_comb begin
        n_pos_x       = r_pos_x;
        n_pos_y       = r_pos_y;
        n_target_x    = r_target_x;
        n_target_y    = r_target_y;
        n_dir_x_neg   = r_dir_x_neg;
        n_dir_y_neg   = r_dir_y_neg;
        n_span_x      = r_span_x;
        n_neg_span_y  = r_neg_span_y;
        n_error_term  = r_error_term;
        n_line_color  = r_line_color;
        n_line_active = r_line_active;
        n_s1          = '0;

        dx  = SPAN_BITS'(i_in.end_x) - SPAN_BITS'(i_in.start_x);
        dy  = SPAN_BITS'(i_in.end_y) - SPAN_BITS'(i_in.start_y);
        ady = dy[SPAN_BITS-1] ? unsigned'(-dy) : unsigned'(dy);

        e2      = {r_error_term, 1'b0};
        nsy_w   = (ERR_BITS + 1)'(r_neg_span_y);
        sx_w    = signed'({2'b0, r_span_x});
        step_x  = e2 >= nsy_w;
        step_y  = e2 <= sx_w;
        err_sum = (ERR_BITS + 1)'(r_error_term) + (step_x ? nsy_w : '0)
                + (step_y ? sx_w : '0);
        pt_x    = step_x ? (r_dir_x_neg ? r_pos_x - 1'b1 : r_pos_x + 1'b1) : r_pos_x;
        pt_y    = step_y ? (r_dir_y_neg ? r_pos_y - 1'b1 : r_pos_y + 1'b1) : r_pos_y;

        if (i_in.mode == MODE_START) begin
            n_pos_x       = i_in.start_x;
            n_pos_y       = i_in.start_y;
            n_target_x    = i_in.end_x;
            n_target_y    = i_in.end_y;
            n_dir_x_neg   = !(i_in.start_x < i_in.end_x);
            n_dir_y_neg   = !(i_in.start_y < i_in.end_y);
            n_span_x      = dx[SPAN_BITS-1] ? unsigned'(-dx) : unsigned'(dx);
            n_neg_span_y  = -signed'({1'b0, ady});
            n_error_term  = ERR_BITS'(signed'({2'b0, n_span_x})) + ERR_BITS'(n_neg_span_y);
            n_line_color  = i_in.color;
            n_s1.pv       = 1'b1;
            n_s1.x        = i_in.start_x;
            n_s1.y        = i_in.start_y;
            n_s1.color    = i_in.color;
            n_s1.last     = (i_in.start_x == i_in.end_x) && (i_in.start_y == i_in.end_y);
            n_line_active = !n_s1.last;
        end else if (r_line_active) begin
            n_pos_x       = pt_x;
            n_pos_y       = pt_y;
            n_error_term  = ERR_BITS'(err_sum);
            n_s1.pv       = 1'b1;
            n_s1.x        = pt_x;
            n_s1.y        = pt_y;
            n_s1.color    = r_line_color;
            n_s1.last     = (pt_x == r_target_x) && (pt_y == r_target_y);
            n_line_active = !n_s1.last;
        end
        // advance with no line: all-zero result, state untouched
    end

    // stage 2: clip test and row offset y * width (times four comes later)
    logic [ADDR_BITS-1:0] uy;

    always_comb begin
        uy         = unsigned'(ADDR_BITS'(r_s1.y));
        n_s2.pt    = r_s1;
        n_s2.on    = !r_s1.x[COORD_BITS-1] && !r_s1.y[COORD_BITS-1]
                  && (ADDR_BITS'(unsigned'(r_s1.x)) < ADDR_BITS'(eff_w))
                  && (ADDR_BITS'(unsigned'(r_s1.y)) < ADDR_BITS'(eff_h));
        n_s2.row_ofs = ADDR_BITS'(uy * ADDR_BITS'(eff_w));
    end

    // stage 3: byte address and write enable
    logic [ADDR_BITS-1:0] ux;

    always_comb begin
        ux   = unsigned'(ADDR_BITS'(r_s2.pt.x));
        n_s3 = '0;
        if (r_s2.pt.pv) begin
            n_s3.point_valid   = 1'b1;
            n_s3.pixel_x       = r_s2.pt.x;
            n_s3.pixel_y       = r_s2.pt.y;
            n_s3.pixel_color   = r_s2.pt.color;
            n_s3.write_enable  = r_mode_enabled && r_s2.on;
            n_s3.pixel_address = r_frame_base + {r_s2.row_ofs[ADDR_BITS-3:0], 2'b00}
                               + {ux[ADDR_BITS-3:0], 2'b00};
            n_s3.last_point    = r_s2.pt.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_enabled  <= 1'b0;
            r_screen_width  <= WIDTH_BITS'(640);
            r_screen_height <= HEIGHT_BITS'(480);
            r_frame_base    <= ADDR_BITS'(32'hF000_0000);
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_target_x      <= '0;
            r_target_y      <= '0;
            r_dir_x_neg     <= 1'b0;
            r_dir_y_neg     <= 1'b0;
            r_span_x        <= '0;
            r_neg_span_y    <= '0;
            r_error_term    <= '0;
            r_line_color    <= '0;
            r_line_active   <= 1'b0;
            r_s1_v          <= 1'b0;
            r_s2_v          <= 1'b0;
            r_s3_v          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE_ENABLED:  r_mode_enabled  <= i_cfg_data[0];
                    CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[WIDTH_BITS-1:0];
                    CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[HEIGHT_BITS-1:0];
                    CFG_FRAME_BASE:    r_frame_base    <= i_cfg_data[ADDR_BITS-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_pos_x       <= n_pos_x;
                r_pos_y       <= n_pos_y;
                r_target_x    <= n_target_x;
                r_target_y    <= n_target_y;
                r_dir_x_neg   <= n_dir_x_neg;
                r_dir_y_neg   <= n_dir_y_neg;
                r_span_x      <= n_span_x;
                r_neg_span_y  <= n_neg_span_y;
                r_error_term  <= n_error_term;
                r_line_color  <= n_line_color;
                r_line_active <= n_line_active;
            end
            if (s1_free) r_s1_v <= i_valid;
            if (s2_free) r_s2_v <= r_s1_v;
            if (s3_free) r_s3_v <= r_s2_v;
        end
    end

    // payload stages, no reset
    always_ff @(posedge i_clk) begin
        if (accept) r_s1 <= n_s1;
        if (s2_free) r_s2 <= n_s2;
        if (s3_free) r_s3 <= n_s3;
    end

endmodule

// File: hdl/blpg_checker.sv
// port-level checker for the bresenham line pixel generator, bound to the top level
`timescale 1ns / 1ps

module blpg_checker
    import blpg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input t_pixel_out o_out
);

    // a held pixel beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("pixel beat changed while stalled");

    // a beat without a point carries nothing at all
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.point_valid |-> o_out == '0)
        else $error("empty beat with nonzero fields");

    // write enable and last flag only on real points
    a_we_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.write_enable || o_out.last_point) |-> o_out.point_valid)
        else $error("write enable or last flag without a point");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pixel beat right after reset");

endmodule

bind bresenham_line_pixel_gen blpg_checker u_blpg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
